[rtl/lcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcw_pkg
// Shared types and constants for the character LCD cursor writer.
// ----------------------------------------------------------------------------
package lcw_pkg;

    // request codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_POS   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_COLUMNS = 3'd0;
    localparam logic [2:0] REG_ROWS    = 3'd1;
    localparam logic [2:0] REG_OFF_A   = 3'd2;
    localparam logic [2:0] REG_OFF_B   = 3'd3;
    localparam logic [2:0] REG_OFF_C   = 3'd4;
    localparam logic [2:0] REG_OFF_D   = 3'd5;

    // character codes
    localparam logic [7:0] CHAR_MIN = 8'd10;
    localparam logic [7:0] CHAR_NL  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;

    // controller command bytes
    localparam logic [7:0] LCD_CLEAR = 8'h01;
    localparam logic [7:0] LCD_HOME  = 8'h02;
    localparam logic [7:0] LCD_DDRAM = 8'h80;

    localparam logic [2:0] MAX_ROWS = 3'd4;

    typedef struct packed {
        logic [6:0]       columns;
        logic [2:0]       rows;
        logic [3:0][6:0]  row_offset;
    } cfg_t;

    // one queued job: one or two bytes, each with its register-select flag
    typedef struct packed {
        logic       two;
        logic       rs0;
        logic [7:0] byte0;
        logic       rs1;
        logic [7:0] byte1;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage
`default_nettype wire

[rtl/char_lcd_cursor_writer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_cursor_writer
// Cursor tracking character LCD writer producing 4-bit controller transfers.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  command, char_code, x_pos, y_pos
//   out      source     out_valid/out_stall  reg_select, nibble, last
//   cfg      APB write  psel/penable/pwrite  paddr, pwdata (prdata readback)
//
// one nibble transaction leaves per cycle while jobs are queued and out_stall is low;
// a request yields 0, 2 or 4 nibbles, set by the nibble counter in the back end
// a request is taken every cycle while the job queue has room
// cursor resets to row 0 column 0, registers to their documented defaults
// output stalls back up through the queue to in_stall, not into the cursor
// ----------------------------------------------------------------------------
module char_lcd_cursor_writer
    import lcw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  char_code,
    input  wire logic [6:0]  x_pos,
    input  wire logic [6:0]  y_pos,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             reg_select,
    output logic [3:0]       nibble,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       push;
    logic       pop;
    job_t       push_job;
    job_t       head_job;
    qstat_t     qstat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns       <= 7'd20;
            cfg_reg.rows          <= 3'd4;
            cfg_reg.row_offset[0] <= 7'd0;
            cfg_reg.row_offset[1] <= 7'd32;
            cfg_reg.row_offset[2] <= 7'd64;
            cfg_reg.row_offset[3] <= 7'd96;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_COLUMNS: cfg_reg.columns       <= pwdata[6:0];
                REG_ROWS:    cfg_reg.rows          <= pwdata[2:0];
                REG_OFF_A:   cfg_reg.row_offset[0] <= pwdata[6:0];
                REG_OFF_B:   cfg_reg.row_offset[1] <= pwdata[6:0];
                REG_OFF_C:   cfg_reg.row_offset[2] <= pwdata[6:0];
                REG_OFF_D:   cfg_reg.row_offset[3] <= pwdata[6:0];
                default:     ; // unmapped registers ignore writes
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COLUMNS: prdata = {25'd0, cfg_reg.columns};
            REG_ROWS:    prdata = {29'd0, cfg_reg.rows};
            REG_OFF_A:   prdata = {25'd0, cfg_reg.row_offset[0]};
            REG_OFF_B:   prdata = {25'd0, cfg_reg.row_offset[1]};
            REG_OFF_C:   prdata = {25'd0, cfg_reg.row_offset[2]};
            REG_OFF_D:   prdata = {25'd0, cfg_reg.row_offset[3]};
            default:     prdata = 32'd0;
        endcase
    end

    lcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .char_code (char_code),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .push      (push),
        .push_job  (push_job)
    );

    lcw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    lcw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reg_select (reg_select),
        .nibble     (nibble),
        .last       (last)
    );

endmodule
`default_nettype wire

[rtl/lcw_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcw_front
// Accepts requests, tracks the cursor and turns each request that needs output into a job.
// ----------------------------------------------------------------------------
module lcw_front
    import lcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] char_code,
    input  wire logic [6:0] x_pos,
    input  wire logic [6:0] y_pos,
    input  wire cfg_t       cfg,
    input  wire qstat_t     qstat,
    output logic            push,
    output job_t            push_job
);

    logic [7:0] cursor_row_reg, cursor_row_next;
    logic [7:0] cursor_col_reg, cursor_col_next;
    logic       accept;
    logic       has_job;
    job_t       job;
    logic [2:0] eff_rows;
    logic [7:0] row_inc;

    function automatic logic [7:0] ddram_cmd(input logic [3:0][6:0] offs,
                                             input logic [1:0] r,
                                             input logic [6:0] x);
        ddram_cmd = LCD_DDRAM | {1'b0, offs[r]} | {1'b0, x};
    endfunction

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;
    assign eff_rows = (cfg.rows > MAX_ROWS) ? MAX_ROWS : cfg.rows;
    assign row_inc  = cursor_row_reg + 8'd1;

    always_comb
    begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        has_job         = 1'b0;
        job             = '0;
        unique case (command)
            CMD_PUT:
            begin
                priority if (char_code < CHAR_MIN || char_code[7])
                begin
                    has_job = 1'b0;
                end
                else if (char_code == CHAR_CR)
                begin
                    cursor_col_next = 8'd0;
                    if (cursor_row_reg < {5'd0, eff_rows})
                    begin
                        has_job   = 1'b1;
                        job.byte0 = ddram_cmd(cfg.row_offset, cursor_row_reg[1:0], 7'd0);
                    end
                end
                else if (char_code == CHAR_NL)
                begin
                    has_job = 1'b1;
                    if (row_inc < {5'd0, eff_rows})
                    begin
                        cursor_row_next = row_inc;
                        cursor_col_next = 8'd0;
                        job.byte0       = ddram_cmd(cfg.row_offset, row_inc[1:0], 7'd0);
                    end
                    else
                    begin
                        cursor_row_next = 8'd0;
                        cursor_col_next = 8'd0;
                        job.two         = 1'b1;
                        job.byte0       = LCD_CLEAR;
                        job.byte1       = LCD_HOME;
                    end
                end
                else if (cursor_col_reg < {1'b0, cfg.columns})
                begin
                    has_job         = 1'b1;
                    job.rs0         = 1'b1;
                    job.byte0       = char_code;
                    cursor_col_next = cursor_col_reg + 8'd1;
                end
                else
                begin
                    has_job = 1'b1;
                    job.two = 1'b1;
                    if (row_inc < {5'd0, eff_rows})
                    begin
                        // wrap: position of the new row, then the character
                        cursor_row_next = row_inc;
                        cursor_col_next = 8'd1;
                        job.byte0       = ddram_cmd(cfg.row_offset, row_inc[1:0], 7'd0);
                        job.rs1         = 1'b1;
                        job.byte1       = char_code;
                    end
                    else
                    begin
                        cursor_row_next = 8'd0;
                        cursor_col_next = 8'd0;
                        job.byte0       = LCD_CLEAR;
                        job.byte1       = LCD_HOME;
                    end
                end
            end
            CMD_POS:
            begin
                cursor_row_next = {1'b0, y_pos};
                cursor_col_next = {1'b0, x_pos};
                if ({1'b0, y_pos} < {5'd0, eff_rows})
                begin
                    has_job   = 1'b1;
                    job.byte0 = ddram_cmd(cfg.row_offset, y_pos[1:0], x_pos);
                end
            end
            CMD_CLEAR:
            begin
                cursor_row_next = 8'd0;
                cursor_col_next = 8'd0;
                has_job         = 1'b1;
                job.two         = 1'b1;
                job.byte0       = LCD_CLEAR;
                job.byte1       = LCD_HOME;
            end
            default:
            begin
                has_job = 1'b0;
            end
        endcase
    end

    assign push     = accept && has_job;
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= 8'd0;
            cursor_col_reg <= 8'd0;
        end
        else if (accept)
        begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
        end
    end

endmodule
`default_nettype wire

[rtl/lcw_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcw_fifo
// Short job queue between the request front end and the transfer back end.
// ----------------------------------------------------------------------------
module lcw_fifo
    import lcw_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output qstat_t    qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_job    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("job popped from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow push");
`endif

endmodule
`default_nettype wire

[rtl/lcw_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcw_back
// Splits queued jobs into nibble transfers, high nibble first.
// ----------------------------------------------------------------------------
module lcw_back
    import lcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire job_t head_job,
    input  wire qstat_t qstat,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic      reg_select,
    output logic [3:0] nibble,
    output logic      last
);

    logic       out_valid_reg;
    logic       rs_reg;
    logic [3:0] nibble_reg;
    logic       last_reg;
    logic [1:0] nib_idx_reg, nib_idx_next;
    logic       load;
    logic       nib_last;
    logic       nib_rs;
    logic [3:0] nib_val;

    assign load     = !qstat.empty && (!out_valid_reg || !out_stall);
    assign nib_last = (nib_idx_reg == 2'd3) || (nib_idx_reg == 2'd1 && !head_job.two);
    assign nib_rs   = nib_idx_reg[1] ? head_job.rs1 : head_job.rs0;

    always_comb
    begin
        unique case (nib_idx_reg)
            2'd0:    nib_val = head_job.byte0[7:4];
            2'd1:    nib_val = head_job.byte0[3:0];
            2'd2:    nib_val = head_job.byte1[7:4];
            default: nib_val = head_job.byte1[3:0];
        endcase
    end

    assign pop          = load && nib_last;
    assign nib_idx_next = nib_last ? 2'd0 : nib_idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            nib_idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            nib_idx_reg   <= nib_idx_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rs_reg     <= nib_rs;
            nibble_reg <= nib_val;
            last_reg   <= nib_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign reg_select = rs_reg;
    assign nibble     = nibble_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire
